### rtl/core/idll_pkg.sv
`timescale 1ns / 1ps
// Shared types, command and status codes for the indexed doubly linked list.
package idll_pkg;

  // Pool size and derived widths.
  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = $clog2(CAPACITY + 1);

  // Command codes carried in the request.
  localparam logic [3:0] CMD_PREPEND    = 4'd0;
  localparam logic [3:0] CMD_APPEND     = 4'd1;
  localparam logic [3:0] CMD_INSERT_AT  = 4'd2;
  localparam logic [3:0] CMD_PEEK_FIRST = 4'd3;
  localparam logic [3:0] CMD_PEEK_LAST  = 4'd4;
  localparam logic [3:0] CMD_READ_AT    = 4'd5;
  localparam logic [3:0] CMD_RM_FIRST   = 4'd6;
  localparam logic [3:0] CMD_RM_LAST    = 4'd7;
  localparam logic [3:0] CMD_RM_AT      = 4'd8;
  localparam logic [3:0] CMD_REPLACE    = 4'd9;
  localparam logic [3:0] CMD_FIND       = 4'd10;

  // Status codes returned with every result.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  // Request payload.
  typedef struct packed {
    logic [3:0]        cmd;
    logic [DATA_W-1:0] data_in;
    logic [POS_W-1:0]  position;
  } in_req_t;

  // Result payload.
  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] data_out;
    logic [IDX_W-1:0]  found_position;
    logic [POS_W-1:0]  element_count;
  } out_rsp_t;

  // What one storage cell does at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHR,
    CELL_SHL,
    CELL_LOAD
  } cell_op_t;

  // Per-cell control from the controller.
  typedef struct packed {
    cell_op_t op;
    logic     kill;
  } cell_ctl_t;

  // Search probe that travels one cell per cycle.
  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] data;
  } probe_t;

endpackage

### rtl/core/idll_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list: holds one element word and one stage of the search probe.
module idll_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  idll_pkg::cell_ctl_t        ctl,
  input  logic [idll_pkg::DATA_W-1:0] load_word,
  input  logic [idll_pkg::DATA_W-1:0] left_word,
  input  logic [idll_pkg::DATA_W-1:0] right_word,
  input  idll_pkg::probe_t           probe_in,
  output logic [idll_pkg::DATA_W-1:0] word,
  output idll_pkg::probe_t           probe_out,
  output logic                       hit
);

  logic [idll_pkg::DATA_W-1:0] word_r;
  logic [idll_pkg::DATA_W-1:0] word_nxt;
  logic                        probe_vld_r;
  logic                        probe_vld_nxt;
  logic [idll_pkg::DATA_W-1:0] probe_data_r;

  // Element word: hold, take a neighbor's word, or load the request word.
  always_comb begin
    case (ctl.op)
      idll_pkg::CELL_SHR:  word_nxt = left_word;
      idll_pkg::CELL_SHL:  word_nxt = right_word;
      idll_pkg::CELL_LOAD: word_nxt = load_word;
      default:             word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // The probe moves on to the next cell every cycle unless the search is over.
  assign probe_vld_nxt = probe_in.vld && !ctl.kill;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_vld_r <= 1'b0;
    end else begin
      probe_vld_r <= probe_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_data_r <= probe_in.data;
  end

  // The probe matches the word held here.
  assign hit           = probe_vld_r && (probe_data_r == word_r);
  assign word          = word_r;
  assign probe_out.vld = probe_vld_r;
  assign probe_out.data = probe_data_r;

endmodule

### rtl/core/idll_ctrl.sv
`timescale 1ns / 1ps
// Command decode, element count, cell control and result register of the list.
module idll_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  idll_pkg::in_req_t           in_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output idll_pkg::out_rsp_t          out_rsp,
  input  logic [idll_pkg::DATA_W-1:0] word_i [idll_pkg::CAPACITY],
  input  logic [idll_pkg::CAPACITY-1:0] hit_i,
  input  logic [idll_pkg::CAPACITY-1:0] probe_vld_i,
  output idll_pkg::cell_ctl_t         ctl_o [idll_pkg::CAPACITY],
  output idll_pkg::probe_t            launch_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FIND = 2'b10
  } state_t;

  state_t                       state_r;
  state_t                       state_nxt;
  logic [idll_pkg::POS_W-1:0]   count_r;
  logic [idll_pkg::POS_W-1:0]   count_nxt;
  logic                         out_vld_r;
  logic                         out_vld_nxt;
  idll_pkg::out_rsp_t           out_rsp_r;
  idll_pkg::out_rsp_t           out_rsp_nxt;

  logic                         accept;
  logic                         full;
  logic                         empty;
  logic [idll_pkg::POS_W-1:0]   last;
  logic [idll_pkg::POS_W-1:0]   tgt;
  logic [1:0]                   stat;
  logic                         rd_en;
  logic                         ins_en;
  logic                         rm_en;
  logic                         rep_en;
  logic                         find_go;
  logic [idll_pkg::POS_W-1:0]   cnt_new;
  logic [idll_pkg::DATA_W-1:0]  rd_word;
  logic [idll_pkg::IDX_W-1:0]   hit_pos;
  logic                         probe_end;

  assign in_ready = (state_r == S_IDLE) && (!out_vld_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == idll_pkg::POS_W'(idll_pkg::CAPACITY));
  assign empty    = (count_r == '0);
  assign last     = count_r - idll_pkg::POS_W'(1);

  // Decode the request against the current element count.
  always_comb begin
    stat    = idll_pkg::STAT_OK;
    tgt     = '0;
    rd_en   = 1'b0;
    ins_en  = 1'b0;
    rm_en   = 1'b0;
    rep_en  = 1'b0;
    find_go = 1'b0;
    case (in_req.cmd)
      idll_pkg::CMD_PREPEND: begin
        if (full) begin
          stat = idll_pkg::STAT_FULL;
        end else begin
          ins_en = 1'b1;
        end
      end
      idll_pkg::CMD_APPEND: begin
        tgt = count_r;
        if (full) begin
          stat = idll_pkg::STAT_FULL;
        end else begin
          ins_en = 1'b1;
        end
      end
      idll_pkg::CMD_INSERT_AT: begin
        tgt = in_req.position;
        if (in_req.position > count_r) begin
          stat = idll_pkg::STAT_RANGE;
        end else if (full) begin
          stat = idll_pkg::STAT_FULL;
        end else begin
          ins_en = 1'b1;
        end
      end
      idll_pkg::CMD_PEEK_FIRST, idll_pkg::CMD_RM_FIRST: begin
        if (empty) begin
          stat = idll_pkg::STAT_RANGE;
        end else begin
          rd_en = 1'b1;
          rm_en = (in_req.cmd == idll_pkg::CMD_RM_FIRST);
        end
      end
      idll_pkg::CMD_PEEK_LAST, idll_pkg::CMD_RM_LAST: begin
        tgt = last;
        if (empty) begin
          stat = idll_pkg::STAT_RANGE;
        end else begin
          rd_en = 1'b1;
          rm_en = (in_req.cmd == idll_pkg::CMD_RM_LAST);
        end
      end
      idll_pkg::CMD_READ_AT, idll_pkg::CMD_RM_AT, idll_pkg::CMD_REPLACE: begin
        tgt = in_req.position;
        if (in_req.position >= count_r) begin
          stat = idll_pkg::STAT_RANGE;
        end else begin
          rd_en  = 1'b1;
          rm_en  = (in_req.cmd == idll_pkg::CMD_RM_AT);
          rep_en = (in_req.cmd == idll_pkg::CMD_REPLACE);
        end
      end
      idll_pkg::CMD_FIND: begin
        if (empty) begin
          stat = idll_pkg::STAT_NOT_FOUND;
        end else begin
          find_go = 1'b1;
        end
      end
      default: begin
        stat = idll_pkg::STAT_RANGE;
      end
    endcase
  end

  // Word at the target position; only used when the position is in range.
  assign rd_word = word_i[tgt[idll_pkg::IDX_W-1:0]];

  always_comb begin
    if (ins_en) begin
      cnt_new = count_r + idll_pkg::POS_W'(1);
    end else if (rm_en) begin
      cnt_new = last;
    end else begin
      cnt_new = count_r;
    end
  end

  // Position of the cell that the probe matched; at most one cell holds the probe.
  always_comb begin
    hit_pos = '0;
    for (int k = 0; k < idll_pkg::CAPACITY; k++) begin
      if (hit_i[k]) begin
        hit_pos = hit_pos | idll_pkg::IDX_W'(k);
      end
    end
  end

  // The probe has reached the last element; a match there takes priority.
  assign probe_end = probe_vld_i[last[idll_pkg::IDX_W-1:0]];

  // Sequencing, cell control and result register.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_vld_nxt   = out_vld_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;
    launch_o.vld  = 1'b0;
    launch_o.data = in_req.data_in;
    for (int k = 0; k < idll_pkg::CAPACITY; k++) begin
      ctl_o[k].op   = idll_pkg::CELL_HOLD;
      ctl_o[k].kill = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (find_go) begin
            launch_o.vld = 1'b1;
            state_nxt    = S_FIND;
          end else begin
            out_vld_nxt                = 1'b1;
            out_rsp_nxt.status         = stat;
            out_rsp_nxt.data_out       = rd_en ? rd_word : '0;
            out_rsp_nxt.found_position = '0;
            out_rsp_nxt.element_count  = cnt_new;
            count_nxt                  = cnt_new;
            for (int k = 0; k < idll_pkg::CAPACITY; k++) begin
              if (ins_en && (idll_pkg::POS_W'(k) > tgt)) begin
                ctl_o[k].op = idll_pkg::CELL_SHR;
              end else if ((ins_en || rep_en) && (idll_pkg::POS_W'(k) == tgt)) begin
                ctl_o[k].op = idll_pkg::CELL_LOAD;
              end else if (rm_en && (idll_pkg::POS_W'(k) >= tgt)) begin
                ctl_o[k].op = idll_pkg::CELL_SHL;
              end
            end
          end
        end
      end
      S_FIND: begin
        if (|hit_i) begin
          out_vld_nxt                = 1'b1;
          out_rsp_nxt.status         = idll_pkg::STAT_OK;
          out_rsp_nxt.data_out       = '0;
          out_rsp_nxt.found_position = hit_pos;
          out_rsp_nxt.element_count  = count_r;
          state_nxt                  = S_IDLE;
          for (int k = 0; k < idll_pkg::CAPACITY; k++) begin
            ctl_o[k].kill = 1'b1;
          end
        end else if (probe_end) begin
          out_vld_nxt                = 1'b1;
          out_rsp_nxt.status         = idll_pkg::STAT_NOT_FOUND;
          out_rsp_nxt.data_out       = '0;
          out_rsp_nxt.found_position = '0;
          out_rsp_nxt.element_count  = count_r;
          state_nxt                  = S_IDLE;
          for (int k = 0; k < idll_pkg::CAPACITY; k++) begin
            ctl_o[k].kill = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_rsp   = out_rsp_r;

  // The element count never goes beyond the pool size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= idll_pkg::POS_W'(idll_pkg::CAPACITY))
    else $error("element count exceeds pool size");

  // Only one cell can ever match, since only one cell holds the probe.
  a_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_i) && $onehot0(probe_vld_i))
    else $error("more than one cell holds or matches the probe");

  // A search never starts while an older result still occupies the register.
  a_find_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIND |-> !out_vld_r)
    else $error("result register busy during a search");

  // Every command other than a search answers at the next edge.
  a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !find_go |=> out_vld_r)
    else $error("single-cycle command produced no result");

  // A search that has just started has its probe in the first cell.
  a_probe_alive: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIND && !$past(state_r == S_FIND) |-> probe_vld_i[0])
    else $error("search started without a probe in the first cell");

endmodule

### rtl/core/indexed_doubly_linked_list.sv
`timescale 1ns / 1ps
// Top level of the indexed doubly linked list: controller and the row of storage cells.
//
// The list keeps up to CAPACITY words in a row of cells held in list order, cell 0
// being the head. Insert and remove commands shift the cells at and beyond the target
// position one place right or left all together, and reads and replace address the
// target cell directly, so every command except find answers in the cycle after it
// is accepted. A find on a non-empty list sends a probe down the row one cell per
// cycle and answers once the probe matches a word, or once it reaches the last element
// without a match. One request is worked on at a time; a new request is taken when
// the block is idle and the result register is empty or being emptied in the same
// cycle. Errors (full pool, empty list, bad position, unused command) leave the list
// unchanged and answer with a zero word.
module indexed_doubly_linked_list (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  idll_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output idll_pkg::out_rsp_t out_rsp
);

  logic [idll_pkg::DATA_W-1:0]  word_w  [idll_pkg::CAPACITY];
  logic [idll_pkg::DATA_W-1:0]  left_w  [idll_pkg::CAPACITY];
  logic [idll_pkg::DATA_W-1:0]  right_w [idll_pkg::CAPACITY];
  idll_pkg::cell_ctl_t          ctl_w   [idll_pkg::CAPACITY];
  idll_pkg::probe_t             probe_w [idll_pkg::CAPACITY + 1];
  logic [idll_pkg::CAPACITY-1:0] hit_w;
  logic [idll_pkg::CAPACITY-1:0] probe_vld_w;

  // Controller.
  idll_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rsp     (out_rsp),
    .word_i      (word_w),
    .hit_i       (hit_w),
    .probe_vld_i (probe_vld_w),
    .ctl_o       (ctl_w),
    .launch_o    (probe_w[0])
  );

  // Row of cells, each linked to its left and right neighbors.
  for (genvar k = 0; k < idll_pkg::CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign left_w[k] = in_req.data_in;
    end else begin : g_left
      assign left_w[k] = word_w[k-1];
    end

    if (k == idll_pkg::CAPACITY - 1) begin : g_tail
      assign right_w[k] = '0;
    end else begin : g_right
      assign right_w[k] = word_w[k+1];
    end

    assign probe_vld_w[k] = probe_w[k+1].vld;

    idll_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl_w[k]),
      .load_word  (in_req.data_in),
      .left_word  (left_w[k]),
      .right_word (right_w[k]),
      .probe_in   (probe_w[k]),
      .word       (word_w[k]),
      .probe_out  (probe_w[k+1]),
      .hit        (hit_w[k])
    );
  end

endmodule
